// ===== src/msk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_pkg
// Shared types and constants for the stack with running maximum.
// ----------------------------------------------------------------------------
package msk_pkg;

	// Stack geometry
	localparam int DEPTH   = 256;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int TOTAL_W = 9;

	// Request codes
	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POP_EMPTY  = 2'd1,
		ST_PUSH_FULL  = 2'd2
	} status_t;

	// Access request from the control logic to the store
	typedef struct packed {
		logic                     wr_en;
		logic [ADDR_W-1:0]        wr_addr;
		logic signed [DATA_W-1:0] wr_value;
		logic signed [DATA_W-1:0] wr_max;
		logic                     rd_en;
		logic [ADDR_W-1:0]        rd_val_addr;
		logic [ADDR_W-1:0]        rd_max_addr;
	} store_req_t;

endpackage

// ===== src/msk_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_req_if / msk_rsp_if
// Valid/ready channels carrying requests into and results out of the stack.
// ----------------------------------------------------------------------------
interface msk_req_if import msk_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, req_type, push_value, input ready);
	modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface msk_rsp_if import msk_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] popped_value;
	logic signed [DATA_W-1:0] stack_max;
	logic [TOTAL_W-1:0]       entry_total;
	logic                     is_empty;
	logic [1:0]               status;

	modport source (output valid, popped_value, stack_max, entry_total, is_empty, status,
		input ready);
	modport sink   (input valid, popped_value, stack_max, entry_total, is_empty, status,
		output ready);
endinterface

// ===== src/msk_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msk_store
// Value memory and companion prefix-maximum memory. Entry i of the max
// memory holds the maximum of entries 0..i, so a pop never rescans.
// ----------------------------------------------------------------------------
module msk_store import msk_pkg::*; (
	input  logic                     clk,
	input  store_req_t               req,
	output logic signed [DATA_W-1:0] rd_value,
	output logic signed [DATA_W-1:0] rd_max
);

	logic signed [DATA_W-1:0] value_mem [DEPTH];
	logic signed [DATA_W-1:0] max_mem   [DEPTH];

	// Value memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			value_mem[req.wr_addr] <= req.wr_value;
		end
		if (req.rd_en) begin
			rd_value <= value_mem[req.rd_val_addr];
		end
	end

	// Prefix-max memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			max_mem[req.wr_addr] <= req.wr_max;
		end
		if (req.rd_en) begin
			rd_max <= max_mem[req.rd_max_addr];
		end
	end

endmodule

// ===== src/stack_with_running_max.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_running_max
// LIFO of signed 32-bit words that reports the maximum of the held words.
// ----------------------------------------------------------------------------
// A request is handled in phases: in the accept cycle a push writes the word
// and its prefix maximum into the store, or a pop issues reads of the top word
// and of the prefix maximum one below it; in the retire cycle, once the output
// register is free or being taken, the registered read data of the store forms
// the result word. No new request is taken while one is in flight. The result
// sits in an output register, so the next request is taken while a result
// still waits; the block holds the following result only if the earlier one
// has not been taken. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module stack_with_running_max import msk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	msk_req_if.sink    req,
	msk_rsp_if.source  rsp
);

	// Architectural state
	logic [CNT_W-1:0]         cnt_q;
	logic signed [DATA_W-1:0] max_q;

	// Request in flight
	logic                     busy_s1;
	logic                     pop_ok_s1;
	logic                     last_s1;
	status_t                  status_s1;

	// Output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] popped_q;
	logic signed [DATA_W-1:0] smax_q;
	logic [CNT_W-1:0]         cnt_out_q;
	status_t                  status_q;

	store_req_t               sreq;
	logic signed [DATA_W-1:0] rd_value;
	logic signed [DATA_W-1:0] rd_max;

	logic                     accept;
	logic                     retire;
	logic                     is_pop;
	logic                     full;
	logic                     empty;
	logic signed [DATA_W-1:0] push_max;
	logic signed [DATA_W-1:0] res_max;

	msk_store u_store (
		.clk      (clk),
		.req      (sreq),
		.rd_value (rd_value),
		.rd_max   (rd_max)
	);

	// Handshake
	assign req.ready = !busy_s1;
	assign accept    = req.valid && !busy_s1;
	assign retire    = busy_s1 && (!out_valid_q || rsp.ready);

	// Request decode
	assign is_pop   = (req_t'(req.req_type) == REQ_POP);
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign push_max = (empty || (req.push_value > max_q)) ? req.push_value : max_q;

	// Store access
	always_comb begin
		sreq             = '0;
		sreq.wr_addr     = ADDR_W'(cnt_q);
		sreq.wr_value    = req.push_value;
		sreq.wr_max      = push_max;
		sreq.rd_val_addr = ADDR_W'(cnt_q - CNT_W'(1));
		sreq.rd_max_addr = ADDR_W'(cnt_q - CNT_W'(2));
		sreq.wr_en       = accept && !is_pop && !full;
		sreq.rd_en       = accept && is_pop && !empty;
	end

	// Maximum after the request being retired
	assign res_max = !pop_ok_s1 ? max_q : (last_s1 ? '0 : rd_max);

	// Control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			max_q       <= '0;
			busy_s1     <= 1'b0;
			pop_ok_s1   <= 1'b0;
			last_s1     <= 1'b0;
			status_s1   <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_s1   <= 1'b1;
				pop_ok_s1 <= is_pop && !empty;
				last_s1   <= (cnt_q == CNT_W'(1));
				unique case (req_t'(req.req_type))
					REQ_PUSH: begin
						if (full) begin
							status_s1 <= ST_PUSH_FULL;
						end else begin
							status_s1 <= ST_OK;
							cnt_q     <= cnt_q + CNT_W'(1);
							max_q     <= push_max;
						end
					end
					REQ_POP: begin
						if (empty) begin
							status_s1 <= ST_POP_EMPTY;
						end else begin
							status_s1 <= ST_OK;
							cnt_q     <= cnt_q - CNT_W'(1);
						end
					end
					default: status_s1 <= ST_OK;
				endcase
			end else if (retire) begin
				busy_s1 <= 1'b0;
				max_q   <= res_max;
			end

			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (retire) begin
			popped_q  <= pop_ok_s1 ? rd_value : '0;
			smax_q    <= res_max;
			cnt_out_q <= cnt_q;
			status_q  <= status_s1;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.stack_max    = smax_q;
	assign rsp.entry_total  = TOTAL_W'(cnt_out_q);
	assign rsp.is_empty     = (cnt_out_q == '0);
	assign rsp.status       = status_q;

endmodule
